[rtl/i2cmbe_pkg.sv]
// ============================================================================
// i2cmbe_pkg - I2C master byte engine shared definitions
// Operation codes, sequencing constants and the result word layout.
// ============================================================================
package i2cmbe_pkg;

    localparam int OP_W = 3;

    localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
    localparam logic [OP_W-1:0] OP_START     = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP      = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE     = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_ACK  = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_NACK = 3'd5;

    // command_kind uses the operation codes; tick code doubles as idle
    localparam logic [OP_W-1:0] KIND_IDLE = OP_TICK;

    localparam logic [3:0] DATA_BITS         = 4'd8;
    localparam logic [7:0] HALF_PERIOD_RESET = 8'd40;

    // Result word, last field in the lowest bit
    typedef struct packed {
        logic       rejected;
        logic       ack_seen;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_out;
        logic       scl_out;
    } res_t;

endpackage

[rtl/i2cmbe_core.sv]
// ============================================================================
// i2cmbe_core - I2C master byte sequencer
// Holds the bus state and half-period timer; updates once per accepted word.
// ============================================================================
module i2cmbe_core #(
    parameter int TICK_COUNTER_WIDTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [7:0]                 cfg_wdata,
    input  logic                       accept,
    input  logic [i2cmbe_pkg::OP_W-1:0] operation,
    input  logic [7:0]                 write_data,
    input  logic                       sda_in,
    output i2cmbe_pkg::res_t           res
);
    import i2cmbe_pkg::*;

    localparam int TW = TICK_COUNTER_WIDTH;
    localparam int CW = ((TW > 8) ? TW : 8) + 1;
    localparam logic [CW-1:0] CAP = CW'((1 << TW) - 1);

    logic [7:0]      half_period_reg;
    logic [OP_W-1:0] kind_reg,  kind_next;
    logic [3:0]      bit_reg,   bit_next;
    logic            phase_reg, phase_next;
    logic [TW-1:0]   tick_reg,  tick_next;
    logic [7:0]      shift_reg, shift_next;
    logic            scl_reg,   scl_next;
    logic            sda_reg,   sda_next;
    logic            ack_reg,   ack_next;
    logic [7:0]      hold_reg,  hold_next;

    logic            done, rej, fin;
    logic [TW:0]     tick_inc;
    logic [CW-1:0]   hp_ext, lim;
    logic [3:0]      bc;
    logic            is_write, is_busy;

    always_comb
    begin
        hp_ext = CW'(half_period_reg);
        if (half_period_reg == 8'd0)
        begin
            lim = CW'(1);
        end
        else if (hp_ext > CAP)
        begin
            lim = CAP;
        end
        else
        begin
            lim = hp_ext;
        end
    end

    assign tick_inc = {1'b0, tick_reg} + (TW+1)'(1);
    assign is_write = (kind_reg == OP_WRITE);
    assign is_busy  = (kind_reg != KIND_IDLE);
    assign bc       = bit_reg + 4'd1;

    always_comb
    begin
        kind_next  = kind_reg;
        bit_next   = bit_reg;
        phase_next = phase_reg;
        tick_next  = tick_reg;
        shift_next = shift_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        hold_next  = hold_reg;
        done       = 1'b0;
        rej        = 1'b0;
        fin        = 1'b0;

        case (operation)
            OP_TICK:
            begin
                if (is_busy)
                begin
                    tick_next = tick_inc[TW-1:0];
                    if (CW'(tick_inc) >= lim)
                    begin
                        tick_next = '0;
                        if (kind_reg == OP_START || kind_reg == OP_STOP)
                        begin
                            if (!phase_reg)
                            begin
                                sda_next   = (kind_reg == OP_START) ? 1'b0 : 1'b1;
                                phase_next = 1'b1;
                            end
                            else
                            begin
                                if (kind_reg == OP_START)
                                begin
                                    scl_next = 1'b0;
                                end
                                fin = 1'b1;
                            end
                        end
                        else if (!phase_reg)
                        begin
                            // end of SCL-high half: sample the line
                            if (is_write)
                            begin
                                if (bit_reg == DATA_BITS)
                                begin
                                    ack_next = sda_in;
                                end
                            end
                            else if (bit_reg < DATA_BITS)
                            begin
                                shift_next = {shift_reg[6:0], sda_in};
                            end
                            scl_next   = 1'b0;
                            phase_next = 1'b1;
                        end
                        else
                        begin
                            bit_next = bc;
                            if (bc > DATA_BITS)
                            begin
                                if (!is_write)
                                begin
                                    hold_next = shift_reg;
                                end
                                fin = 1'b1;
                            end
                            else
                            begin
                                if (is_write)
                                begin
                                    sda_next = (bc >= DATA_BITS) ? 1'b1
                                             : shift_reg[3'(4'd7 - bc)];
                                end
                                else if (bc == DATA_BITS)
                                begin
                                    sda_next = (kind_reg == OP_READ_ACK) ? 1'b0 : 1'b1;
                                end
                                else
                                begin
                                    sda_next = 1'b1;
                                end
                                scl_next   = 1'b1;
                                phase_next = 1'b0;
                            end
                        end
                        if (fin)
                        begin
                            kind_next  = KIND_IDLE;
                            bit_next   = 4'd0;
                            phase_next = 1'b0;
                            done       = 1'b1;
                        end
                    end
                end
            end
            OP_START, OP_STOP, OP_WRITE, OP_READ_ACK, OP_READ_NACK:
            begin
                if (is_busy)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    kind_next  = operation;
                    bit_next   = 4'd0;
                    phase_next = 1'b0;
                    tick_next  = '0;
                    scl_next   = 1'b1;
                    case (operation)
                        OP_START: sda_next = 1'b1;
                        OP_STOP:  sda_next = 1'b0;
                        OP_WRITE:
                        begin
                            shift_next = write_data;
                            sda_next   = write_data[7];
                        end
                        default:
                        begin
                            shift_next = 8'd0;
                            sda_next   = 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
                // unknown codes are dropped without effect
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
            kind_reg        <= KIND_IDLE;
            bit_reg         <= 4'd0;
            phase_reg       <= 1'b0;
            tick_reg        <= '0;
            shift_reg       <= 8'd0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            ack_reg         <= 1'b1;
            hold_reg        <= 8'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                half_period_reg <= cfg_wdata;
            end
            if (accept)
            begin
                kind_reg  <= kind_next;
                bit_reg   <= bit_next;
                phase_reg <= phase_next;
                tick_reg  <= tick_next;
                shift_reg <= shift_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                ack_reg   <= ack_next;
                hold_reg  <= hold_next;
            end
        end
    end

    always_comb
    begin
        res.scl_out   = scl_next;
        res.sda_out   = sda_next;
        res.busy_res  = (kind_next != KIND_IDLE);
        res.done_res  = done;
        res.read_data = hold_next;
        res.ack_seen  = ack_next;
        res.rejected  = rej;
    end

endmodule

[rtl/i2cmbe_obuf.sv]
// ============================================================================
// i2cmbe_obuf - result register with skid stage
// Two-entry output buffer so input is taken while a result is stalled.
// ============================================================================
module i2cmbe_obuf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  i2cmbe_pkg::res_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output i2cmbe_pkg::res_t out_data
);
    import i2cmbe_pkg::*;

    logic out_valid_reg;
    logic sk_valid_reg;
    res_t out_reg;
    res_t sk_reg;
    logic in_acc;
    logic out_free;

    assign in_ready  = !sk_valid_reg;
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sk_valid_reg  <= 1'b0;
        end
        else if (in_acc)
        begin
            if (out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                sk_valid_reg <= 1'b1;
            end
        end
        else if (out_valid_reg && out_ready)
        begin
            if (sk_valid_reg)
            begin
                sk_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            if (out_free)
            begin
                out_reg <= in_data;
            end
            else
            begin
                sk_reg <= in_data;
            end
        end
        else if (out_valid_reg && out_ready && sk_valid_reg)
        begin
            out_reg <= sk_reg;
        end
    end

endmodule

[rtl/i2c_master_byte_engine.sv]
// ============================================================================
// i2c_master_byte_engine - byte-level open-drain I2C master
// Sequences start, stop, write and read commands on SCL/SDA from tick words.
// ============================================================================
// Usage:
//   Slave stream: each word is a command (start, stop, write, read+ack,
//   read+nack) or a tick that carries the sampled SDA level. Ticks pace the
//   bus; an SCL half-period lasts half_period_ticks ticks (0 acts as 1).
//   Master stream: exactly one result word per input word, holding the SCL
//   and SDA drive levels, busy/done flags, last read byte, last ack sample
//   and a rejected flag for a command issued while busy.
//   Result: registered in the output register, or in the skid entry on a stall.
//   Throughput: one word per cycle while s_tready is high; each update is
//   one pass of counter step and phase logic between the state registers.
//   Stall: a result register plus one skid entry decouple the sides, so one
//   more word is taken while a result waits; s_tready drops once both hold.
//   Reset: bus released (SCL and SDA high), engine idle, ack_seen 1,
//   half_period_ticks 40, output buffer empty.
//   Config writes (cfg_we) are meant for idle periods only.
// ============================================================================
module i2c_master_byte_engine #(
    parameter int TICK_COUNTER_WIDTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: half_period_ticks
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] write_data, [8] sda_in, rest zero
    input  logic [2:0]  s_tuser,   // [2:0] operation
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] scl_out, [1] sda_out, [2] busy_res,
                                   // [3] done_res, [11:4] read_data,
                                   // [12] ack_seen, [13] rejected, rest zero
);
    import i2cmbe_pkg::*;

    logic accept;
    res_t core_res;
    res_t out_res;

    assign accept = s_tvalid && s_tready;

    i2cmbe_core #(
        .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .accept     (accept),
        .operation  (s_tuser),
        .write_data (s_tdata[7:0]),
        .sda_in     (s_tdata[8]),
        .res        (core_res)
    );

    // result register and skid entry
    i2cmbe_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (core_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {2'b00, out_res};

endmodule
